FILE: src/agc_pkg.sv
`default_nettype none
package agc_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned MagW    = 17;
	localparam int unsigned GainW   = 24;
	localparam int unsigned LevelW  = 15;
	localparam int unsigned RateW   = 16;
	localparam int unsigned WideW   = 27;
	localparam int unsigned ProdW   = MagW + WideW;
	localparam int unsigned SumW    = 29;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 24;

	localparam logic [GainW-1:0] ONE_GAIN = 24'd16384;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TARGET = 3'd0,
		REG_MAXG   = 3'd1,
		REG_ATTACK = 3'd2,
		REG_DECAY  = 3'd3,
		REG_CLIP   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_DIFF,
		ST_STEP,
		ST_GAIN,
		ST_OUT
	} state_t;

	typedef enum logic {
		MUL_MAG_GAIN,
		MUL_RATE_DIFF
	} mul_sel_t;

	typedef struct packed {
		logic [LevelW-1:0] target_level;
		logic [GainW-1:0]  max_gain;
		logic [RateW-1:0]  attack_rate;
		logic [RateW-1:0]  decay_rate;
		logic [LevelW-1:0] clip_level;
	} cfg_t;

	typedef struct packed {
		logic     ld_in;
		mul_sel_t mul_sel;
		logic     en_mag;
		logic     en_diff;
		logic     en_step;
		logic     en_gain;
		logic     ld_out;
	} ctrl_t;

endpackage
`default_nettype wire

FILE: src/agc_cfg.sv
`default_nettype none
module agc_cfg
	import agc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgDatW-1:0] cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_level <= 15'd9830;
			cfg_q.max_gain     <= 24'd16384000;
			cfg_q.attack_rate  <= 16'd32768;
			cfg_q.decay_rate   <= 16'd328;
			cfg_q.clip_level   <= 15'd32440;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: cfg_q.target_level <= cfg_data[LevelW-1:0];
				REG_MAXG:   cfg_q.max_gain     <= cfg_data[GainW-1:0];
				REG_ATTACK: cfg_q.attack_rate  <= cfg_data[RateW-1:0];
				REG_DECAY:  cfg_q.decay_rate   <= cfg_data[RateW-1:0];
				REG_CLIP:   cfg_q.clip_level   <= cfg_data[LevelW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: src/agc_ctrl.sv
`default_nettype none
module agc_ctrl
	import agc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic out_busy,
	output logic      in_stall,
	output ctrl_t     ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG:  state_d = ST_DIFF;
			ST_DIFF: state_d = ST_STEP;
			ST_STEP: state_d = ST_GAIN;
			ST_GAIN: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MUL_MAG_GAIN;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				ctrl.ld_in  = in_valid;
			end
			ST_MAG:  ctrl.en_mag = 1'b1;
			ST_DIFF: ctrl.en_diff = 1'b1;
			ST_STEP: begin
				ctrl.mul_sel = MUL_RATE_DIFF;
				ctrl.en_step = 1'b1;
			end
			ST_GAIN: ctrl.en_gain = 1'b1;
			ST_OUT:  ctrl.ld_out = !out_busy;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: src/agc_dp.sv
`default_nettype none
module agc_dp
	import agc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire ctrl_t               ctrl,
	input  wire logic [SampleW-1:0]  sample,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output logic                     out_busy,
	output logic signed [SampleW-1:0] audio,
	output logic [GainW-1:0]         current_gain
);

	logic              neg_q;
	logic [MagW-1:0]   mag_q;
	logic [GainW-1:0]  gain_q;
	logic [WideW-1:0]  m_q;
	logic [WideW-1:0]  diff_q;
	logic [RateW-1:0]  rate_q;
	logic              dn_q;
	logic [WideW-1:0]  step_q;
	logic              out_valid_q;
	logic [SampleW-1:0] audio_q;
	logic [GainW-1:0]  cur_gain_q;

	logic [MagW-1:0]   mul_a;
	logic [WideW-1:0]  mul_b;
	logic [ProdW-1:0]  prod;
	logic [ProdW-1:0]  rnd;
	logic [WideW-1:0]  scaled;
	logic [MagW-1:0]   mag_d;
	logic signed [SumW-1:0] g_sum;
	logic signed [SumW-1:0] g_max;
	logic [GainW-1:0]  g_new;
	logic [LevelW-1:0] y_clip;

	// shared multiplier
	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_MAG_GAIN: begin
				mul_a = mag_q;
				mul_b = {{(WideW-GainW){1'b0}}, gain_q};
			end
			MUL_RATE_DIFF: begin
				mul_a = {1'b0, rate_q};
				mul_b = diff_q;
			end
			default: begin
				mul_a = mag_q;
				mul_b = {{(WideW-GainW){1'b0}}, gain_q};
			end
		endcase
	end

	assign prod   = ProdW'(mul_a) * ProdW'(mul_b);
	assign rnd    = prod + ProdW'(32768);
	assign scaled = prod[WideW+13:14];

	assign mag_d = sample[SampleW-1] ? MagW'(17'h10000 - {1'b0, sample}) : {1'b0, sample};

	assign g_sum = dn_q ? ($signed({{(SumW-GainW){1'b0}}, gain_q})
	                     - $signed({{(SumW-WideW){1'b0}}, step_q}))
	                    : ($signed({{(SumW-GainW){1'b0}}, gain_q})
	                     + $signed({{(SumW-WideW){1'b0}}, step_q}));
	assign g_max = $signed({{(SumW-GainW){1'b0}}, cfg.max_gain});

	always_comb begin
		logic signed [SumW-1:0] g;
		g = g_sum;
		if (g > g_max) begin
			g = g_max;
		end
		if (g < $signed({{(SumW-GainW){1'b0}}, ONE_GAIN})) begin
			g = $signed({{(SumW-GainW){1'b0}}, ONE_GAIN});
		end
		g_new = g[GainW-1:0];
	end

	assign y_clip = (scaled > {{(WideW-LevelW){1'b0}}, cfg.clip_level})
	                ? cfg.clip_level : scaled[LevelW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ONE_GAIN;
		end else if (ctrl.en_gain) begin
			gain_q <= g_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_in) begin
			neg_q <= sample[SampleW-1];
			mag_q <= mag_d;
		end
		if (ctrl.en_mag) begin
			m_q <= scaled;
		end
		if (ctrl.en_diff) begin
			if (m_q > {{(WideW-LevelW){1'b0}}, cfg.target_level}) begin
				dn_q   <= 1'b1;
				diff_q <= m_q - {{(WideW-LevelW){1'b0}}, cfg.target_level};
				rate_q <= cfg.attack_rate;
			end else begin
				dn_q   <= 1'b0;
				diff_q <= {{(WideW-LevelW){1'b0}}, cfg.target_level} - m_q;
				rate_q <= cfg.decay_rate;
			end
		end
		if (ctrl.en_step) begin
			step_q <= rnd[WideW+15:16];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			audio_q    <= neg_q ? SampleW'(17'h10000 - {2'b0, y_clip})
			                    : {1'b0, y_clip};
			cur_gain_q <= gain_q;
		end
	end

	assign out_busy     = out_valid_q && out_stall;
	assign out_valid    = out_valid_q;
	assign audio        = $signed(audio_q);
	assign current_gain = cur_gain_q;

endmodule
`default_nettype wire

FILE: src/audio_agc_attack_decay_core.sv
`default_nettype none
// Audio gain control with attack and decay. Each sample beat (signed Q1.15) is
// scaled by the running Q10.14 gain; the magnitude is compared with target_level
// and the gain is lowered by attack_rate times the excess or raised by decay_rate
// times the shortfall, then held between 1.0 and max_gain. The sample scaled by
// the new gain and clipped to plus or minus clip_level leaves as one result beat
// with the new gain. An accepted sample goes through ST_MAG, ST_DIFF, ST_STEP,
// ST_GAIN and ST_OUT into the output register and no new sample is taken before
// then, as one 17x27 multiplier is used three times in turn under a small
// sequencer; in_stall stays high meanwhile and while a finished result is held
// back by out_stall. The user must write registers through cfg_we/cfg_index/
// cfg_data only while idle (not enforced); indexes beyond clip_level are ignored.
module audio_agc_attack_decay_core
	import agc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [CfgDatW-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic signed [SampleW-1:0] sample,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [SampleW-1:0] audio,
	output logic [GainW-1:0]          current_gain
);

	cfg_t  cfg;
	ctrl_t ctrl;
	logic  out_busy;

	agc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	agc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_busy (out_busy),
		.in_stall (in_stall),
		.ctrl     (ctrl)
	);

	agc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ctrl         (ctrl),
		.sample       (sample),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_busy     (out_busy),
		.audio        (audio),
		.current_gain (current_gain)
	);

endmodule
`default_nettype wire
